// ----- rtl/rid_pkg.sv -----
// Shared types and constants of the radial interference detector.
`default_nettype none

package rid_pkg;

  // Angle codes that mean "no peak recorded"
  localparam logic [15:0]        AZ_UNDEF = 16'd36000;
  localparam logic signed [14:0] EL_UNDEF = 15'sd9001;

  // Sun proximity window, hundredths of a degree
  localparam int SUN_WIN = 200;

  // Radial status codes
  localparam logic [1:0] STAT_BOV = 2'd1;
  localparam logic [1:0] STAT_EOV = 2'd2;

  // Slots of the peak angle store
  localparam int ANG_SUN_H = 0;
  localparam int ANG_SUN_V = 1;
  localparam int ANG_OTH_H = 2;
  localparam int ANG_OTH_V = 3;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_PULSE_LONG   = 3'd0,
    CFG_H_BASE_SHORT = 3'd1,
    CFG_V_BASE_SHORT = 3'd2,
    CFG_H_BASE_LONG  = 3'd3,
    CFG_V_BASE_LONG  = 3'd4,
    CFG_NOISE_MARGIN = 3'd5
  } cfg_idx_e;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_SUN_H = 3'd1,
    KIND_SUN_V = 3'd2,
    KIND_EXC_H = 3'd3,
    KIND_EXC_V = 3'd4
  } kind_e;

  // Radial position
  typedef struct packed {
    logic [15:0]        az;
    logic signed [14:0] el;
  } ang_t;

  // Selected bases and thresholds, handed from the register bank
  typedef struct packed {
    logic signed [15:0] h_base;
    logic signed [15:0] v_base;
    logic signed [16:0] h_thr;
    logic signed [16:0] v_thr;
  } lvl_t;

  // Snapshot of the accumulators for one report
  typedef struct packed {
    logic signed [15:0] h_sun_peak;
    logic signed [15:0] v_sun_peak;
    logic signed [15:0] h_oth_peak;
    logic signed [15:0] v_oth_peak;
    logic [15:0]        h_cnt;
    logic [15:0]        v_cnt;
    ang_t [3:0]         ang;
  } rpt_t;

endpackage

`default_nettype wire

// ----- rtl/rid_front.sv -----
// Front end: takes radial items, updates the accumulators, queues reports.
`default_nettype none

module rid_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [103:0]  s_axis_tdata,
  input  wire logic [0:0]    s_axis_tuser,
  input  wire rid_pkg::lvl_t lvl_i,
  input  wire logic          q_ready_i,
  output logic               q_push_o,
  output rid_pkg::rpt_t      q_data_o
);

  // Input stage
  logic        s1_valid_q, s1_valid_d;
  logic        s1_action_q;
  logic [96:0] s1_data_q;

  // Accumulators
  logic               lv_valid_q, lv_valid_d;
  logic [15:0]        h_cnt_q, h_cnt_d, v_cnt_q, v_cnt_d;
  logic signed [15:0] h_sun_q, h_sun_d, v_sun_q, v_sun_d;
  logic signed [15:0] h_oth_q, h_oth_d, v_oth_q, v_oth_d;
  rid_pkg::ang_t [3:0] ang_q, ang_d;

  // Unpacked fields of the staged item
  logic signed [15:0] h_noise, v_noise;
  logic signed [16:0] h_ext, v_ext;
  logic [15:0]        azimuth, sun_az;
  logic signed [14:0] elevation, sun_el;
  logic [1:0]         status;
  logic               first_el;
  rid_pkg::ang_t      here;

  logic signed [16:0] d_az;
  logic signed [15:0] d_el;
  logic signed [16:0] win_az;
  logic signed [15:0] win_el;
  logic               near_sun, h_exc, v_exc, due, rpt, go;

  assign h_noise   = s1_data_q[15:0];
  assign v_noise   = s1_data_q[31:16];
  assign azimuth   = s1_data_q[47:32];
  assign elevation = s1_data_q[62:48];
  assign sun_az    = s1_data_q[78:63];
  assign sun_el    = s1_data_q[93:79];
  assign status    = s1_data_q[95:94];
  assign first_el  = s1_data_q[96];
  assign here      = '{az: azimuth, el: elevation};

  assign h_ext = {h_noise[15], h_noise};
  assign v_ext = {v_noise[15], v_noise};

  // Threshold tests
  assign h_exc = h_ext > lvl_i.h_thr;
  assign v_exc = v_ext > lvl_i.v_thr;

  // Sun window, plain codes with no wrap
  assign win_az   = 17'(rid_pkg::SUN_WIN);
  assign win_el   = 16'(rid_pkg::SUN_WIN);
  assign d_az     = $signed({1'b0, sun_az}) - $signed({1'b0, azimuth});
  assign d_el     = $signed({sun_el[14], sun_el}) - $signed({elevation[14], elevation});
  assign near_sun = (d_az <= win_az) && (d_az >= -win_az) &&
                    (d_el <= win_el) && (d_el >= -win_el);

  // Accumulator update
  always_comb begin
    lv_valid_d = lv_valid_q;
    h_cnt_d    = h_cnt_q;
    v_cnt_d    = v_cnt_q;
    h_sun_d    = h_sun_q;
    v_sun_d    = v_sun_q;
    h_oth_d    = h_oth_q;
    v_oth_d    = v_oth_q;
    ang_d      = ang_q;
    if (s1_action_q) begin
      h_cnt_d = '0;
      v_cnt_d = '0;
      h_sun_d = lvl_i.h_base;
      h_oth_d = lvl_i.h_base;
      v_sun_d = lvl_i.v_base;
      v_oth_d = lvl_i.v_base;
      for (int i = 0; i < 4; i++) begin
        ang_d[i] = '{az: rid_pkg::AZ_UNDEF, el: rid_pkg::EL_UNDEF};
      end
      lv_valid_d = 1'b1;
    end else if (lv_valid_q && (h_exc || v_exc)) begin
      if (near_sun) begin
        if (h_noise > h_sun_q) begin
          h_sun_d                  = h_noise;
          ang_d[rid_pkg::ANG_SUN_H] = here;
        end
        if (v_noise > v_sun_q) begin
          v_sun_d                  = v_noise;
          ang_d[rid_pkg::ANG_SUN_V] = here;
        end
      end else begin
        if (h_exc) begin
          if (h_cnt_q != 16'hFFFF) h_cnt_d = h_cnt_q + 16'd1;
          if (h_noise > h_oth_q) begin
            h_oth_d                  = h_noise;
            ang_d[rid_pkg::ANG_OTH_H] = here;
          end
        end
        if (v_exc) begin
          if (v_cnt_q != 16'hFFFF) v_cnt_d = v_cnt_q + 16'd1;
          if (v_noise > v_oth_q) begin
            v_oth_d                  = v_noise;
            ang_d[rid_pkg::ANG_OTH_V] = here;
          end
        end
      end
    end
    if (rpt) lv_valid_d = 1'b0;
  end

  // Report decision on the updated counts
  assign due = (status == rid_pkg::STAT_EOV) ||
               ((status == rid_pkg::STAT_BOV) && first_el &&
                ((h_cnt_d != 16'd0) || (v_cnt_d != 16'd0)));
  assign rpt = !s1_action_q && lv_valid_q && due;

  // Advance the staged item unless its report finds the queue full
  assign go            = s1_valid_q && (!rpt || q_ready_i);
  assign s_axis_tready = !s1_valid_q || go;
  assign q_push_o      = go && rpt;

  assign q_data_o = '{h_sun_peak: h_sun_d, v_sun_peak: v_sun_d,
                      h_oth_peak: h_oth_d, v_oth_peak: v_oth_d,
                      h_cnt: h_cnt_d, v_cnt: v_cnt_d, ang: ang_d};

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s_axis_tvalid && s_axis_tready) s1_valid_d = 1'b1;
    else if (go)                        s1_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      lv_valid_q <= 1'b0;
      h_cnt_q    <= '0;
      v_cnt_q    <= '0;
      h_sun_q    <= '0;
      v_sun_q    <= '0;
      h_oth_q    <= '0;
      v_oth_q    <= '0;
      for (int i = 0; i < 4; i++) begin
        ang_q[i] <= '{az: rid_pkg::AZ_UNDEF, el: rid_pkg::EL_UNDEF};
      end
    end else begin
      s1_valid_q <= s1_valid_d;
      if (go) begin
        lv_valid_q <= lv_valid_d;
        h_cnt_q    <= h_cnt_d;
        v_cnt_q    <= v_cnt_d;
        h_sun_q    <= h_sun_d;
        v_sun_q    <= v_sun_d;
        h_oth_q    <= h_oth_d;
        v_oth_q    <= v_oth_d;
        ang_q      <= ang_d;
      end
    end
  end

  // Payload of the input stage
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_action_q <= s_axis_tuser[0];
      s1_data_q   <= s_axis_tdata[96:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rid_queue.sv -----
// Short report queue between the front end and the result sequencer.
`default_nettype none

module rid_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire rid_pkg::rpt_t data_i,
  output logic               ready_o,
  output logic               valid_o,
  output rid_pkg::rpt_t      data_o,
  input  wire logic          pop_i
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  rid_pkg::rpt_t entry_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign ready_o = cnt_q != FULL_CNT;
  assign valid_o = cnt_q != '0;
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
    if (do_pop)  rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
    if (do_push && !do_pop)      cnt_d = cnt_q + CW'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= data_i;
  end

endmodule

`default_nettype wire

// ----- rtl/rid_back.sv -----
// Back end: walks one queued report and sends its result items in order.
`default_nettype none

module rid_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire rid_pkg::lvl_t lvl_i,
  input  wire logic          q_valid_i,
  input  wire rid_pkg::rpt_t q_data_i,
  output logic               q_pop_o,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [63:0]        m_axis_tdata,
  output logic [2:0]         m_axis_tuser,
  output logic               m_axis_tlast
);

  logic [3:0] sent_q, sent_d;
  logic [3:0] mask, rem, sel, rest;
  logic       sun, out_free, step, emit;

  logic               m_valid_q, m_valid_d;
  logic [2:0]         kind_q, kind_d;
  logic               last_q;
  logic [15:0]        cnt_q, cnt_d;
  logic signed [15:0] lvl_q, lvl_d;
  rid_pkg::ang_t      ang_q, ang_d;

  // Which items this report holds, in sending order
  assign sun  = ($signed({q_data_i.h_sun_peak[15], q_data_i.h_sun_peak}) > lvl_i.h_thr) ||
                ($signed({q_data_i.v_sun_peak[15], q_data_i.v_sun_peak}) > lvl_i.v_thr);
  assign mask = {q_data_i.v_cnt != 16'd0, q_data_i.h_cnt != 16'd0, sun, sun};
  assign rem  = mask & ~sent_q;
  assign sel  = rem & (~rem + 4'd1);
  assign rest = rem & ~sel;

  assign out_free = !m_valid_q || m_axis_tready;
  assign step     = q_valid_i && out_free;
  assign emit     = step && (rem != 4'd0);
  assign q_pop_o  = step && (rest == 4'd0);

  always_comb begin
    sent_d = sent_q;
    if (q_pop_o)   sent_d = '0;
    else if (emit) sent_d = sent_q | sel;
  end

  // Pick the fields of the next item
  always_comb begin
    priority if (rem[0]) begin
      kind_d = rid_pkg::KIND_SUN_H;
      cnt_d  = '0;
      lvl_d  = q_data_i.h_sun_peak;
      ang_d  = q_data_i.ang[rid_pkg::ANG_SUN_H];
    end else if (rem[1]) begin
      kind_d = rid_pkg::KIND_SUN_V;
      cnt_d  = '0;
      lvl_d  = q_data_i.v_sun_peak;
      ang_d  = q_data_i.ang[rid_pkg::ANG_SUN_V];
    end else if (rem[2]) begin
      kind_d = rid_pkg::KIND_EXC_H;
      cnt_d  = q_data_i.h_cnt;
      lvl_d  = q_data_i.h_oth_peak;
      ang_d  = q_data_i.ang[rid_pkg::ANG_OTH_H];
    end else begin
      kind_d = rid_pkg::KIND_EXC_V;
      cnt_d  = q_data_i.v_cnt;
      lvl_d  = q_data_i.v_oth_peak;
      ang_d  = q_data_i.ang[rid_pkg::ANG_OTH_V];
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (emit)               m_valid_d = 1'b1;
    else if (m_axis_tready) m_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      sent_q    <= sent_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q <= kind_d;
      cnt_q  <= cnt_d;
      lvl_q  <= lvl_d;
      ang_q  <= ang_d;
      last_q <= rest == 4'd0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = {1'b0, ang_q.el, ang_q.az, lvl_q, cnt_q};

endmodule

`default_nettype wire

// ----- rtl/radial_interference_detector_top.sv -----
// Top level of the radial interference detector: register bank and the front/back pair.
//
//  channel  dir  payload
//  s_axis   in   tdata: h_noise, v_noise, azimuth, elevation, sun_azimuth,
//                       sun_elevation, radial_status, first_elevation; tuser: action
//  m_axis   out  tdata: radial_count, peak_level, peak_azimuth, peak_elevation;
//                tuser: kind; tlast: last
//  cfg      in   write enable, register index, 16-bit data
//
// The front end takes one item a cycle into its input stage and retires it from there
// into the accumulators; it holds only when a report meets a full queue (QDEPTH reports).
// The back end sends one result item a cycle from the queue head while m_axis_tready
// does not stall it; it pops each report with its last item, an empty one without sending.
// Reset clears all control state at once; no clearing pass follows.
// Output stalls fill the queue and then reach the input through tready.
`default_nettype none

module radial_interference_detector_top #(
  parameter int QDEPTH = 2
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // h_noise[15:0], v_noise[31:16], azimuth[47:32], elevation[62:48],
  // sun_azimuth[78:63], sun_elevation[93:79], radial_status[95:94],
  // first_elevation[96], zero fill above
  input  wire logic [103:0] s_axis_tdata,
  // action[0]
  input  wire logic [0:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // radial_count[15:0], peak_level[31:16], peak_azimuth[47:32],
  // peak_elevation[62:48], zero fill above
  output logic [63:0]       m_axis_tdata,
  // kind[2:0]
  output logic [2:0]        m_axis_tuser,
  output logic              m_axis_tlast,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [15:0]  cfg_data_i
);

  logic               pulse_long_q;
  logic signed [15:0] h_bs_q, v_bs_q, h_bl_q, v_bl_q;
  logic [14:0]        margin_q;

  rid_pkg::lvl_t lvl;
  rid_pkg::rpt_t push_data, head_data;
  logic          q_ready, q_push, q_valid, q_pop;

  // Register bank
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_long_q <= 1'b0;
      h_bs_q       <= '0;
      v_bs_q       <= '0;
      h_bl_q       <= '0;
      v_bl_q       <= '0;
      margin_q     <= 15'd640;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rid_pkg::CFG_PULSE_LONG:   pulse_long_q <= cfg_data_i[0];
        rid_pkg::CFG_H_BASE_SHORT: h_bs_q       <= cfg_data_i;
        rid_pkg::CFG_V_BASE_SHORT: v_bs_q       <= cfg_data_i;
        rid_pkg::CFG_H_BASE_LONG:  h_bl_q       <= cfg_data_i;
        rid_pkg::CFG_V_BASE_LONG:  v_bl_q       <= cfg_data_i;
        rid_pkg::CFG_NOISE_MARGIN: margin_q     <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Select bases and form thresholds exactly at 17 bits
  always_comb begin
    lvl.h_base = pulse_long_q ? h_bl_q : h_bs_q;
    lvl.v_base = pulse_long_q ? v_bl_q : v_bs_q;
    lvl.h_thr  = {lvl.h_base[15], lvl.h_base} + $signed({2'b00, margin_q});
    lvl.v_thr  = {lvl.v_base[15], lvl.v_base} + $signed({2'b00, margin_q});
  end

  rid_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .lvl_i         (lvl),
    .q_ready_i     (q_ready),
    .q_push_o      (q_push),
    .q_data_o      (push_data)
  );

  rid_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_data),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .data_o  (head_data),
    .pop_i   (q_pop)
  );

  rid_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .lvl_i         (lvl),
    .q_valid_i     (q_valid),
    .q_data_i      (head_data),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ----- rtl/rid_checker.sv -----
// Port-level checks on the result stream, bound to the top level.
`default_nettype none

module rid_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // Hold a stalled item
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result item changed while stalled");

  // Only real kinds leave the block
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tuser == rid_pkg::KIND_SUN_H) || (m_axis_tuser == rid_pkg::KIND_SUN_V) ||
      (m_axis_tuser == rid_pkg::KIND_EXC_H) || (m_axis_tuser == rid_pkg::KIND_EXC_V))
    else $error("result item of no kind");

  // Sun items carry no count, excess items a nonzero one
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (((m_axis_tuser == rid_pkg::KIND_SUN_H) || (m_axis_tuser == rid_pkg::KIND_SUN_V)) ==
       (m_axis_tdata[15:0] == 16'd0)))
    else $error("count does not match kind");

  // Sun H is never the last item, excess V always is
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ((m_axis_tuser != rid_pkg::KIND_SUN_H) || !m_axis_tlast) &&
      ((m_axis_tuser != rid_pkg::KIND_EXC_V) || m_axis_tlast))
    else $error("last flag out of order");

  // Sun V follows an accepted sun H
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && (m_axis_tuser == rid_pkg::KIND_SUN_H) |=>
      !m_axis_tvalid || (m_axis_tuser == rid_pkg::KIND_SUN_V))
    else $error("sun V item missing after sun H");

endmodule

bind radial_interference_detector_top rid_checker u_rid_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
